[hw/rtl/dtfe_pkg.sv]
// shared types, command codes and calendar helpers for the date and time field editor
`default_nettype none

package dtfe_pkg;

   // key commands
   typedef enum logic [2:0] {
      OP_LOAD   = 3'd0,
      OP_TOGGLE = 3'd1,
      OP_NEXT   = 3'd2,
      OP_INC    = 3'd3,
      OP_DEC    = 3'd4
   } opcode_type;

   // field select codes
   localparam logic [2:0] FLD_YEAR   = 3'd0;
   localparam logic [2:0] FLD_MONTH  = 3'd1;
   localparam logic [2:0] FLD_DAY    = 3'd2;
   localparam logic [2:0] FLD_HOUR   = 3'd3;
   localparam logic [2:0] FLD_MINUTE = 3'd4;
   localparam logic [2:0] FLD_SECOND = 3'd5;

   // field limits
   localparam logic [6:0] YEAR_MAX   = 7'd99;
   localparam logic [3:0] MONTH_MAX  = 4'd12;
   localparam logic [4:0] HOUR_MAX   = 5'd23;
   localparam logic [5:0] MINSEC_MAX = 6'd59;

   typedef struct packed {
      logic [2:0] opcode;
      logic [6:0] load_year;
      logic [3:0] load_month;
      logic [4:0] load_day;
      logic [4:0] load_hour;
      logic [5:0] load_minute;
      logic [5:0] load_second;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] year_out;
      logic [3:0] month_out;
      logic [4:0] day_out;
      logic [4:0] hour_out;
      logic [5:0] minute_out;
      logic [5:0] second_out;
      logic [2:0] selected_field;
      logic       set_mode;
      logic       write_clock;
   } rsp_payload_type;

   // days in month, leap february when year mod 4 is zero, all other month codes give 31
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
      logic [4:0] len;
      case (month)
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2:                    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   // next field select, wraps after the second field
   function automatic logic [2:0] next_field(input logic [2:0] idx);
      logic [2:0] nxt;
      case (idx)
         3'd5:    nxt = 3'd0;
         3'd6:    nxt = 3'd1;
         3'd7:    nxt = 3'd2;
         default: nxt = idx + 3'd1;
      endcase
      return nxt;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/dtfe_if.sv]
// valid/ready channel interfaces for command and result transfers
`default_nettype none

interface dtfe_req_if import dtfe_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dtfe_rsp_if import dtfe_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/date_time_field_editor_unit.sv]
// top level of the key-driven date and time field editor
//
// usage
//  - req_chan carries one key command per transfer: load from clock, mode
//    toggle, next field, increment or decrement, plus the six load values
//  - rsp_chan returns exactly one result per command: all six fields after
//    the command, the selected field, the mode and the write-to-clock strobe
//  - results are registered: a command's result is loaded into the output
//    register when it is free or being read, else into the skid register
//  - throughput is one command per cycle while req_chan.ready is high; the
//    field state gets a single wrap and day-length pass at the accepting edge
//  - results sit in an output register backed by one skid register, so a
//    command is still taken while one result waits; req_chan.ready drops only
//    when both are full
//  - reset (synchronous, active high) empties both result registers and sets
//    year 0, month 1, day 1, time 00:00:00, field 0, show mode
`default_nettype none

module date_time_field_editor_unit import dtfe_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   dtfe_req_if.sink  req_chan,
   dtfe_rsp_if.source rsp_chan
);

   // field state
   logic [6:0] year_ff,   year_in;
   logic [3:0] month_ff,  month_in;
   logic [4:0] day_ff,    day_in;
   logic [4:0] hour_ff,   hour_in;
   logic [5:0] minute_ff, minute_in;
   logic [5:0] second_ff, second_in;
   logic [2:0] field_ff,  field_in;
   logic       mode_ff,   mode_in;
   logic       wr_clk;

   // result buffering
   logic            out_valid_ff,  out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type out_data_ff,   out_data_in;
   rsp_payload_type skid_data_ff,  skid_data_in;
   rsp_payload_type result;

   logic push;
   logic pop;

   // increment and decrement candidates
   logic [4:0] dim_inc;
   logic [4:0] dim_dec;
   logic [6:0] yr_dec;
   logic [3:0] mo_dec_raw;
   logic [3:0] mo_dec;
   logic [4:0] dy_dec_raw;
   logic [4:0] dy_dec;

   assign req_chan.ready = !skid_valid_ff;
   assign push = req_chan.valid && req_chan.ready;
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   // day length for increment uses the fields as they stand
   assign dim_inc = month_len(month_ff, year_ff);

   // decrement path: step the selected field, then repair month and day
   always_comb begin
      yr_dec     = year_ff;
      mo_dec_raw = month_ff;
      dy_dec_raw = day_ff;
      if (field_ff == FLD_YEAR) begin
         yr_dec = (year_ff == 7'd0) ? YEAR_MAX : year_ff - 7'd1;
      end
      if (field_ff == FLD_MONTH) begin
         mo_dec_raw = (month_ff <= 4'd1) ? MONTH_MAX : month_ff - 4'd1;
      end
      if (field_ff == FLD_DAY) begin
         dy_dec_raw = (day_ff == 5'd0) ? 5'd0 : day_ff - 5'd1;
      end
      mo_dec  = (mo_dec_raw == 4'd0) ? MONTH_MAX : mo_dec_raw;
      dim_dec = month_len(mo_dec, yr_dec);
      if (dy_dec_raw == 5'd0) begin
         dy_dec = dim_dec;
      end else if (dy_dec_raw > dim_dec) begin
         dy_dec = 5'd1;
      end else begin
         dy_dec = dy_dec_raw;
      end
   end

   // command decode and next field state
   always_comb begin
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      field_in  = field_ff;
      mode_in   = mode_ff;
      wr_clk    = 1'b0;
      case (req_chan.payload.opcode)
         OP_LOAD: begin
            // clock chip values only land in show mode
            if (!mode_ff) begin
               year_in   = req_chan.payload.load_year;
               month_in  = req_chan.payload.load_month;
               day_in    = req_chan.payload.load_day;
               hour_in   = req_chan.payload.load_hour;
               minute_in = req_chan.payload.load_minute;
               second_in = req_chan.payload.load_second;
            end
         end
         OP_TOGGLE: begin
            // leaving set mode strobes a write back to the clock chip
            if (mode_ff) begin
               mode_in  = 1'b0;
               field_in = FLD_YEAR;
               wr_clk   = 1'b1;
            end else begin
               mode_in = 1'b1;
            end
         end
         OP_NEXT: begin
            field_in = next_field(field_ff);
         end
         OP_INC: begin
            case (field_ff)
               FLD_YEAR:   year_in   = (year_ff >= YEAR_MAX) ? 7'd0 : year_ff + 7'd1;
               FLD_MONTH:  month_in  = (month_ff >= MONTH_MAX) ? 4'd1 : month_ff + 4'd1;
               FLD_DAY:    day_in    = (day_ff >= dim_inc) ? 5'd1 : day_ff + 5'd1;
               FLD_HOUR:   hour_in   = (hour_ff >= HOUR_MAX) ? 5'd0 : hour_ff + 5'd1;
               FLD_MINUTE: minute_in = (minute_ff >= MINSEC_MAX) ? 6'd0 : minute_ff + 6'd1;
               FLD_SECOND: second_in = (second_ff >= MINSEC_MAX) ? 6'd0 : second_ff + 6'd1;
               default:    ;
            endcase
         end
         OP_DEC: begin
            year_in  = yr_dec;
            month_in = mo_dec;
            day_in   = dy_dec;
            case (field_ff)
               FLD_HOUR:   hour_in   = (hour_ff == 5'd0) ? HOUR_MAX : hour_ff - 5'd1;
               FLD_MINUTE: minute_in = (minute_ff == 6'd0) ? MINSEC_MAX : minute_ff - 6'd1;
               FLD_SECOND: second_in = (second_ff == 6'd0) ? MINSEC_MAX : second_ff - 6'd1;
               default:    ;
            endcase
         end
         default: ;
      endcase

      result.year_out       = year_in;
      result.month_out      = month_in;
      result.day_out        = day_in;
      result.hour_out       = hour_in;
      result.minute_out     = minute_in;
      result.second_out     = second_in;
      result.selected_field = field_in;
      result.set_mode       = mode_in;
      result.write_clock    = wr_clk;
   end

   // output register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no transfer in while the skid entry is held
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff       <= 7'd0;
         month_ff      <= 4'd1;
         day_ff        <= 5'd1;
         hour_ff       <= 5'd0;
         minute_ff     <= 6'd0;
         second_ff     <= 6'd0;
         field_ff      <= FLD_YEAR;
         mode_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            year_ff   <= year_in;
            month_ff  <= month_in;
            day_ff    <= day_in;
            hour_ff   <= hour_in;
            minute_ff <= minute_in;
            second_ff <= second_in;
            field_ff  <= field_in;
            mode_ff   <= mode_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // a held skid entry always has a result in front of it
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   // the write strobe only comes with the return to show mode
   a_write_in_show: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.write_clock) |-> !rsp_chan.payload.set_mode)
      else $error("write strobe while still in set mode");

   // the edited field never leaves the six real fields
   a_field_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.selected_field <= FLD_SECOND))
      else $error("selected field out of range");

   // a transfer into an empty result stage shows up the next cycle
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push && !out_valid_ff) |=> out_valid_ff)
      else $error("accepted command produced no result");

endmodule

`default_nettype wire
